// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DBT_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define DBT_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/dbt_pkg.sv =====
// Package of the tokenizer: command codes, register indexes, types and set lookup.
package dbt_pkg;

    localparam int SET_SIZE              = 4;
    localparam int PENDING_DEPTH_DEFAULT = 16;
    localparam int Q_DEPTH               = 4;
    localparam int Q_AW                  = 2;
    localparam int Q_CW                  = 3;

    // A set register holds four bytes, so a count saturates at the smaller limit.
    localparam logic [2:0] SET_LIMIT = 3'((SET_SIZE < 4) ? SET_SIZE : 4);

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_SEP_SET     = 3'd0;
    localparam logic [2:0] REG_SEP_COUNT   = 3'd1;
    localparam logic [2:0] REG_ESCAPE      = 3'd2;
    localparam logic [2:0] REG_SKIP_EMPTY  = 3'd3;
    localparam logic [2:0] REG_LEAD_SET    = 3'd4;
    localparam logic [2:0] REG_LEAD_COUNT  = 3'd5;
    localparam logic [2:0] REG_TRAIL_SET   = 3'd6;
    localparam logic [2:0] REG_TRAIL_COUNT = 3'd7;

    // Commands passed from the front end to the back end.
    localparam logic [1:0] OP_END     = 2'd0;
    localparam logic [1:0] OP_DISCARD = 2'd1;
    localparam logic [1:0] OP_PUSH    = 2'd2;
    localparam logic [1:0] OP_EMIT    = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } cmd_t;

    function automatic logic in_set(logic [31:0] set, logic [2:0] count, logic [7:0] b);
        logic       hit;
        logic [2:0] lim;
        hit = 1'b0;
        lim = (count > SET_LIMIT) ? SET_LIMIT : count;
        for (int i = 0; i < 4; i++) begin
            if ((3'(i) < lim) && (set[8*i +: 8] == b)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== rtl/dbt_if.sv =====
// Channel interfaces of the tokenizer: byte input, token output and register writes.
interface dbt_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface dbt_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic [7:0] end_separator;
    logic       last;

    modport source (output valid, output kind, output out_byte, output end_separator,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input end_separator,
                    input last, output ready);
endinterface

interface dbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/delimiter_byte_tokenizer_core.sv =====
// Top level of the delimiter byte tokenizer: front end, command queue and back end.
//
//   Channel       Role   Payload                                   Transfer when
//   byte_stream   sink   func, in_byte                             valid && ready
//   token_stream  source kind, out_byte, end_separator, last       valid && ready
//   cfg           sink   index (3 bits), data (32 bits)            valid && ready
//
// A plain token byte, a separator or an end of stream is written to the command queue and
// its result is then loaded into the output register, so one byte a cycle flows through
// while the output is not stalled. A byte that flushes k held trail bytes gives k + 1
// results: the back end takes the command, then gives one result at a time. A trail
// byte that overflows a full store gives one result; a held trail byte gives none.
// Reset is asynchronous and active low; it clears all control state at once, with no
// clearing pass, since only held bytes that were written are ever read.
// The four-entry command queue lets the front end keep taking bytes while the back end
// waits on a stalled output; the input stalls only when that queue is full.
module delimiter_byte_tokenizer_core #(
    parameter int PENDING_DEPTH = dbt_pkg::PENDING_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    dbt_cfg_if.sink   cfg,
    dbt_in_if.sink    byte_stream,
    dbt_out_if.source token_stream
);

    // Commands travel from the classifier to the back end through this queue.
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    dbt_pkg::cmd_t q_push_cmd;
    dbt_pkg::cmd_t q_pop_cmd;

    // The front end owns the registers and the token state, and decides what each
    // byte does; it keeps its own count of held bytes to spot a full ring.
    dbt_front #(.PENDING_DEPTH(PENDING_DEPTH)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .byte_stream (byte_stream),
        .q_push      (q_push),
        .q_cmd       (q_push_cmd),
        .q_full      (q_full)
    );

    dbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    // The back end keeps the held trail bytes in a ring and produces every result.
    dbt_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_cmd        (q_pop_cmd),
        .q_pop        (q_pop),
        .token_stream (token_stream)
    );

endmodule

// ===== rtl/dbt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dbt_queue.sv =====
// Short command queue between the front end and the back end.
module dbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dbt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output dbt_pkg::cmd_t pop_cmd,
    output logic          empty
);

    dbt_pkg::cmd_t                entries_reg [dbt_pkg::Q_DEPTH];
    logic [dbt_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dbt_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dbt_pkg::Q_CW-1:0]     count_reg, count_next;

    assign full    = (count_reg == dbt_pkg::Q_CW'(dbt_pkg::Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/dbt_front.sv =====
// Front end: configuration registers, token state and byte classification.
module dbt_front #(
    parameter int PENDING_DEPTH = dbt_pkg::PENDING_DEPTH_DEFAULT,
    localparam int PW           = $clog2(PENDING_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    dbt_cfg_if.sink       cfg,
    dbt_in_if.sink        byte_stream,
    output logic          q_push,
    output dbt_pkg::cmd_t q_cmd,
    input  logic          q_full
);

    logic [31:0] sep_set_reg;
    logic [2:0]  sep_count_reg;
    logic [7:0]  escape_reg;
    logic        skip_empty_reg;
    logic [31:0] lead_set_reg;
    logic [2:0]  lead_count_reg;
    logic [31:0] trail_set_reg;
    logic [2:0]  trail_count_reg;

    logic          esc_pend_reg, esc_pend_next;
    logic          at_start_reg, at_start_next;
    logic          nonempty_reg, nonempty_next;
    logic [PW-1:0] fcnt_reg, fcnt_next;

    logic accept;
    logic is_esc, is_sep, is_lead, is_trail;

    assign cfg.ready         = 1'b1;
    assign byte_stream.ready = !q_full;
    assign accept            = byte_stream.valid && !q_full;

    assign is_esc   = (escape_reg != 8'd0) && (byte_stream.in_byte == escape_reg);
    assign is_sep   = dbt_pkg::in_set(sep_set_reg, sep_count_reg, byte_stream.in_byte);
    assign is_lead  = dbt_pkg::in_set(lead_set_reg, lead_count_reg, byte_stream.in_byte);
    assign is_trail = dbt_pkg::in_set(trail_set_reg, trail_count_reg, byte_stream.in_byte);

    always_comb
    begin
        esc_pend_next = esc_pend_reg;
        at_start_next = at_start_reg;
        nonempty_next = nonempty_reg;
        fcnt_next     = fcnt_reg;
        q_push        = 1'b0;
        q_cmd.op      = dbt_pkg::OP_EMIT;
        q_cmd.data    = byte_stream.in_byte;
        if (accept)
        begin
            if (byte_stream.func)
            begin
                q_push     = 1'b1;
                q_cmd.data = 8'd0;
                q_cmd.op   = (!skip_empty_reg || nonempty_reg) ? dbt_pkg::OP_END
                                                               : dbt_pkg::OP_DISCARD;
                esc_pend_next = 1'b0;
                at_start_next = 1'b1;
                nonempty_next = 1'b0;
                fcnt_next     = '0;
            end
            else if (esc_pend_reg)
            begin
                q_push        = 1'b1;
                esc_pend_next = 1'b0;
                at_start_next = 1'b0;
                nonempty_next = 1'b1;
                fcnt_next     = '0;
            end
            else if (is_esc)
            begin
                esc_pend_next = 1'b1;
            end
            else if (is_sep)
            begin
                if (!(at_start_reg && skip_empty_reg))
                begin
                    q_push        = 1'b1;
                    q_cmd.op      = dbt_pkg::OP_END;
                    at_start_next = 1'b1;
                    nonempty_next = 1'b0;
                    fcnt_next     = '0;
                end
            end
            else if (at_start_reg && is_lead)
            begin
                // Lead strip byte at token start is dropped.
            end
            else if (is_trail)
            begin
                q_push        = 1'b1;
                q_cmd.op      = dbt_pkg::OP_PUSH;
                at_start_next = 1'b0;
                if (fcnt_reg == PW'(PENDING_DEPTH))
                begin
                    // The oldest held byte goes out to make room.
                    nonempty_next = 1'b1;
                end
                else
                begin
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end
            else
            begin
                q_push        = 1'b1;
                at_start_next = 1'b0;
                nonempty_next = 1'b1;
                fcnt_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pend_reg    <= 1'b0;
            at_start_reg    <= 1'b1;
            nonempty_reg    <= 1'b0;
            fcnt_reg        <= '0;
            sep_set_reg     <= '0;
            sep_count_reg   <= '0;
            escape_reg      <= '0;
            skip_empty_reg  <= 1'b0;
            lead_set_reg    <= '0;
            lead_count_reg  <= '0;
            trail_set_reg   <= '0;
            trail_count_reg <= '0;
        end
        else
        begin
            esc_pend_reg <= esc_pend_next;
            at_start_reg <= at_start_next;
            nonempty_reg <= nonempty_next;
            fcnt_reg     <= fcnt_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    dbt_pkg::REG_SEP_SET:     sep_set_reg     <= cfg.data;
                    dbt_pkg::REG_SEP_COUNT:   sep_count_reg   <= cfg.data[2:0];
                    dbt_pkg::REG_ESCAPE:      escape_reg      <= cfg.data[7:0];
                    dbt_pkg::REG_SKIP_EMPTY:  skip_empty_reg  <= cfg.data[0];
                    dbt_pkg::REG_LEAD_SET:    lead_set_reg    <= cfg.data;
                    dbt_pkg::REG_LEAD_COUNT:  lead_count_reg  <= cfg.data[2:0];
                    dbt_pkg::REG_TRAIL_SET:   trail_set_reg   <= cfg.data;
                    dbt_pkg::REG_TRAIL_COUNT: trail_count_reg <= cfg.data[2:0];
                    default:                  sep_set_reg     <= sep_set_reg;
                endcase
            end
        end
    end

endmodule

// ===== rtl/dbt_back.sv =====
// Back end: pending trail byte ring and the registered result output.
module dbt_back #(
    parameter int PENDING_DEPTH = dbt_pkg::PENDING_DEPTH_DEFAULT,
    localparam int PW           = $clog2(PENDING_DEPTH + 1),
    localparam int AW           = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  dbt_pkg::cmd_t q_cmd,
    output logic          q_pop,
    dbt_out_if.source     token_stream
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;

    logic [1:0]    state_reg, state_next;
    dbt_pkg::cmd_t cmd_reg, cmd_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [PW-1:0] cnt_reg, cnt_next;

    logic       ov_reg, ov_next;
    logic       okind_reg, okind_next;
    logic [7:0] obyte_reg, obyte_next;
    logic [7:0] osep_reg, osep_next;
    logic       olast_reg, olast_next;

    logic       out_free;
    logic       load;
    logic       ram_we;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;

    function automatic logic [AW-1:0] ptr_inc(logic [AW-1:0] p);
        return (p == AW'(PENDING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free = !ov_reg || token_stream.ready;

    // The read address follows the next head, so the oldest byte is ready in the next cycle.
    dbt_ram #(.WIDTH(8), .DEPTH(PENDING_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_wdata  = q_cmd.data;
        load       = 1'b0;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        osep_next  = osep_reg;
        olast_next = olast_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_cmd.op)
                        dbt_pkg::OP_DISCARD:
                        begin
                            q_pop     = 1'b1;
                            head_next = '0;
                            tail_next = '0;
                            cnt_next  = '0;
                        end
                        dbt_pkg::OP_END:
                        begin
                            if (out_free)
                            begin
                                q_pop      = 1'b1;
                                load       = 1'b1;
                                okind_next = 1'b1;
                                obyte_next = 8'd0;
                                osep_next  = q_cmd.data;
                                olast_next = 1'b1;
                                head_next  = '0;
                                tail_next  = '0;
                                cnt_next   = '0;
                            end
                        end
                        dbt_pkg::OP_PUSH:
                        begin
                            q_pop = 1'b1;
                            if (cnt_reg == PW'(PENDING_DEPTH))
                            begin
                                cmd_next   = q_cmd;
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = ptr_inc(tail_reg);
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg != '0)
                            begin
                                q_pop      = 1'b1;
                                cmd_next   = q_cmd;
                                state_next = ST_DRAIN;
                            end
                            else if (out_free)
                            begin
                                q_pop      = 1'b1;
                                load       = 1'b1;
                                okind_next = 1'b0;
                                obyte_next = q_cmd.data;
                                osep_next  = 8'd0;
                                olast_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = 1'b0;
                    obyte_next = ram_rdata;
                    osep_next  = 8'd0;
                    olast_next = (cmd_reg.op == dbt_pkg::OP_PUSH);
                    head_next  = ptr_inc(head_reg);
                    if (cmd_reg.op == dbt_pkg::OP_PUSH)
                    begin
                        // Full ring: the freed slot takes the new trail byte.
                        ram_we     = 1'b1;
                        ram_wdata  = cmd_reg.data;
                        tail_next  = ptr_inc(tail_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == PW'(1))
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = 1'b0;
                    obyte_next = cmd_reg.data;
                    osep_next  = 8'd0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        ov_next = load ? 1'b1 : (token_stream.ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        okind_reg <= okind_next;
        obyte_reg <= obyte_next;
        osep_reg  <= osep_next;
        olast_reg <= olast_next;
    end

    assign token_stream.valid         = ov_reg;
    assign token_stream.kind          = okind_reg;
    assign token_stream.out_byte      = obyte_reg;
    assign token_stream.end_separator = osep_reg;
    assign token_stream.last          = olast_reg;

endmodule

// ===== rtl/dbt_checker.sv =====
// Port checker of the tokenizer and its binding to the top level.
`include "assert_macros.svh"

module dbt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_kind,
    input logic [7:0] out_byte,
    input logic [7:0] out_sep,
    input logic       out_last
);

    `DBT_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
    `DBT_ASSERT_NEXT(a_data_hold, out_valid && !out_ready, $stable(out_byte) && $stable(out_sep) && $stable(out_kind) && $stable(out_last), "result changed while stalled")
    `DBT_ASSERT_NOW(a_end_is_last, !out_valid || !out_kind || (out_last && (out_byte == 8'd0)), "token end not last or carries a byte")
    `DBT_ASSERT_NOW(a_byte_no_sep, !out_valid || out_kind || (out_sep == 8'd0), "token byte carries a separator")

endmodule

bind delimiter_byte_tokenizer_core dbt_checker u_dbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (token_stream.valid),
    .out_ready (token_stream.ready),
    .out_kind  (token_stream.kind),
    .out_byte  (token_stream.out_byte),
    .out_sep   (token_stream.end_separator),
    .out_last  (token_stream.last)
);
